### rtl/core/assert_macros.svh
// assertion macros shared by the ranking core rtl
// needs clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/core/ptkrs_pkg.sv
// shared constants, types and helpers of the top-k row select core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptkrs_pkg;

  localparam int MAX_K      = 16;
  localparam int IDX_W      = $clog2(MAX_K);
  localparam int CNT_W      = $clog2(MAX_K + 1);
  localparam int ROW_W      = 16;
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int PART_W     = 4;
  localparam int RANK_W     = 4;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE           = 2'd0,
    REG_SELECT_COUNT   = 2'd1,
    REG_ZERO_THRESHOLD = 2'd2
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PROBE  = 7'b0000010,
    ST_MUL_A  = 7'b0000100,
    ST_MUL_B  = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_COUNT  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul_a;
    logic mul_b;
    logic insert;
    logic ptr_inc;
    logic count;
    logic load_found;
    logic load_none;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic cand_in;
    logic in_last;
    logic last;
    logic mode;
    logic slot_valid;
    logic ptr_at_end;
    logic gt;
    logic tie_win;
    logic n_zero;
    logic emit_last;
    logic out_free;
  } status_t;

  // select count clamped to 1..MAX_K
  function automatic logic [CNT_W-1:0] eff_k(input logic [SIZE_W-1:0] sc);
    logic [CNT_W-1:0] k;
    if (int'(sc) > MAX_K) begin
      k = CNT_W'(MAX_K);
    end else if (sc == '0) begin
      k = CNT_W'(1);
    end else begin
      k = CNT_W'(sc);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ptkrs_dpath.sv
// datapath: config registers, kept slots, shared multiplier, output register
// depends on ptkrs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptkrs_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ptkrs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ptkrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [ptkrs_pkg::ROW_W-1:0]       row_i,
  input  wire logic [ptkrs_pkg::VAL_W-1:0]       infeasibility_i,
  input  wire logic [ptkrs_pkg::VAL_W-1:0]       weight_i,
  input  wire logic [ptkrs_pkg::PART_W-1:0]      partition_i,
  input  wire logic                              last_i,
  input  wire ptkrs_pkg::cmd_t                   cmd_i,
  output ptkrs_pkg::status_t                     status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ptkrs_pkg::ROW_W-1:0]            chosen_row_o,
  output logic                                   found_o,
  output logic [ptkrs_pkg::RANK_W-1:0]           rank_o,
  output logic [ptkrs_pkg::SIZE_W-1:0]           list_size_o,
  output logic                                   end_of_list_o
);
  import ptkrs_pkg::*;

  logic                mode_q;
  logic [SIZE_W-1:0]   select_count_q;
  logic [VAL_W-1:0]    threshold_q;
  logic                cfg_clear;

  logic [ROW_W-1:0]    row_q;
  logic [VAL_W-1:0]    inf_q;
  logic [VAL_W-1:0]    weight_q;
  logic                last_q;

  logic [ROW_W-1:0]    kept_row_q [MAX_K];
  logic [VAL_W-1:0]    kept_inf_q [MAX_K];
  logic [VAL_W-1:0]    kept_weight_q [MAX_K];
  logic [MAX_K-1:0]    kept_valid_q;

  logic [IDX_W-1:0]    ptr_q;
  logic [IDX_W-1:0]    emit_q;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    n_d;
  logic [CNT_W-1:0]    k_eff;
  logic [IDX_W-1:0]    k_last;

  logic [VAL_W-1:0]    op_a;
  logic [VAL_W-1:0]    op_b;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   prod_a_q;
  logic [PROD_W-1:0]   prod_b_q;

  logic                out_valid_q;
  logic [ROW_W-1:0]    out_row_q;
  logic                out_found_q;
  logic [RANK_W-1:0]   out_rank_q;
  logic [SIZE_W-1:0]   out_size_q;
  logic                out_eol_q;

  assign k_eff  = eff_k(select_count_q);
  assign k_last = IDX_W'(k_eff - CNT_W'(1));

  // rewriting mode or count empties the kept slots of the scan in progress
  assign cfg_clear = cfg_we_i &&
                     (cfg_index_i == REG_MODE || cfg_index_i == REG_SELECT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      select_count_q <= SIZE_W'(8);
      threshold_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:           mode_q         <= cfg_data_i[0];
        REG_SELECT_COUNT:   select_count_q <= cfg_data_i[SIZE_W-1:0];
        REG_ZERO_THRESHOLD: threshold_q    <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // captured row
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q    <= row_i;
      inf_q    <= infeasibility_i;
      weight_q <= weight_i;
      last_q   <= last_i;
    end
  end

  // slot pointer, emission rank and list size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      emit_q <= '0;
      n_q    <= '0;
    end else begin
      if (cmd_i.capture) begin
        ptr_q <= mode_q ? IDX_W'(partition_i) : '0;
      end else if (cmd_i.count) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + IDX_W'(1);
      end
      if (cmd_i.count) begin
        emit_q <= '0;
        n_q    <= n_d;
      end else if (cmd_i.load_found) begin
        emit_q <= emit_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    n_d = '0;
    for (int i = 0; i < MAX_K; i++) begin
      if (kept_valid_q[i] && i < int'(k_eff)) begin
        n_d = n_d + CNT_W'(1);
      end
    end
  end

  // one shared multiplier, two passes per compare
  assign op_a = cmd_i.mul_b ? kept_inf_q[ptr_q] : inf_q;
  assign op_b = cmd_i.mul_b ? weight_q : kept_weight_q[ptr_q];
  assign prod = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      prod_a_q <= prod;
    end
    if (cmd_i.mul_b) begin
      prod_b_q <= prod;
    end
  end

  // kept slots: in global mode the tail below the insert point moves down one
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      if (!mode_q) begin
        for (int j = 1; j < MAX_K; j++) begin
          if (IDX_W'(j) > ptr_q && j < int'(k_eff)) begin
            kept_row_q[j]    <= kept_row_q[j-1];
            kept_inf_q[j]    <= kept_inf_q[j-1];
            kept_weight_q[j] <= kept_weight_q[j-1];
          end
        end
      end
      kept_row_q[ptr_q]    <= row_q;
      kept_inf_q[ptr_q]    <= inf_q;
      kept_weight_q[ptr_q] <= weight_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_valid_q <= '0;
    end else if (cfg_clear || cmd_i.clear) begin
      kept_valid_q <= '0;
    end else if (cmd_i.insert) begin
      if (!mode_q) begin
        for (int j = 1; j < MAX_K; j++) begin
          if (IDX_W'(j) > ptr_q && j < int'(k_eff)) begin
            kept_valid_q[j] <= kept_valid_q[j-1];
          end
        end
      end
      kept_valid_q[ptr_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_found || cmd_i.load_none) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_found) begin
      out_row_q   <= kept_row_q[ptr_q];
      out_found_q <= 1'b1;
      out_rank_q  <= RANK_W'(emit_q);
      out_size_q  <= SIZE_W'(n_q);
      out_eol_q   <= status_o.emit_last;
    end else if (cmd_i.load_none) begin
      out_row_q   <= '0;
      out_found_q <= 1'b0;
      out_rank_q  <= '0;
      out_size_q  <= '0;
      out_eol_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign chosen_row_o  = out_row_q;
  assign found_o       = out_found_q;
  assign rank_o        = out_rank_q;
  assign list_size_o   = out_size_q;
  assign end_of_list_o = out_eol_q;

  always_comb begin
    status_o            = '0;
    status_o.cand_in    = (infeasibility_i > threshold_q) &&
                          (!mode_q || int'(partition_i) < int'(k_eff));
    status_o.in_last    = last_i;
    status_o.last       = last_q;
    status_o.mode       = mode_q;
    status_o.slot_valid = kept_valid_q[ptr_q];
    status_o.ptr_at_end = (ptr_q == k_last);
    status_o.gt         = (prod_a_q > prod_b_q);
    status_o.tie_win    = (prod_a_q == prod_b_q) && (row_q < kept_row_q[ptr_q]);
    status_o.n_zero     = (n_q == '0);
    status_o.emit_last  = ((CNT_W'(emit_q) + CNT_W'(1)) == n_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  `ASSERT_CLK(a_insert_sets_valid, cmd_i.insert && !cfg_we_i |=> kept_valid_q[$past(ptr_q)], "inserted slot not marked valid")
  `ASSERT_CLK(a_global_prefix, !mode_q |-> ((kept_valid_q & (kept_valid_q + MAX_K'(1))) == '0), "global slots not a sorted prefix")
  `ASSERT_NEVER(a_emit_empty_slot, cmd_i.load_found && !kept_valid_q[ptr_q], "empty slot sent as a result")

endmodule

`default_nettype wire

### rtl/core/ptkrs_ctrl.sv
// controller: sequences probing, compare passes, insertion and list emission
// depends on ptkrs_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptkrs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ptkrs_pkg::status_t   status_i,
  output ptkrs_pkg::cmd_t           cmd_o
);
  import ptkrs_pkg::*;

  state_e state_q;
  state_e state_d;
  state_e done_st;

  assign done_st    = status_i.last ? ST_COUNT : ST_IDLE;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (status_i.cand_in) begin
            state_d = ST_PROBE;
          end else if (status_i.in_last) begin
            state_d = ST_COUNT;
          end
        end
      end
      ST_PROBE: begin
        if (!status_i.slot_valid) begin
          cmd_o.insert = 1'b1;
          state_d      = done_st;
        end else begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.gt || (!status_i.mode && status_i.tie_win)) begin
          cmd_o.insert = 1'b1;
          state_d      = done_st;
        end else if (status_i.mode || status_i.ptr_at_end) begin
          state_d = done_st;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = ST_PROBE;
        end
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.n_zero) begin
          if (status_i.out_free) begin
            cmd_o.load_none = 1'b1;
            cmd_o.clear     = 1'b1;
            state_d         = ST_IDLE;
          end
        end else if (status_i.slot_valid) begin
          if (status_i.out_free) begin
            cmd_o.load_found = 1'b1;
            if (status_i.emit_last) begin
              cmd_o.clear = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              cmd_o.ptr_inc = 1'b1;
            end
          end
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_mul_order, cmd_o.mul_b |-> $past(cmd_o.mul_a), "second product without first")
  `ASSERT_CLK(a_load_needs_room, (cmd_o.load_found || cmd_o.load_none) |-> status_i.out_free, "result word loaded over an unsent one")

endmodule

`default_nettype wire

### rtl/core/pricing_top_k_row_select_core.sv
// top level of the streaming top-k row select core
// depends on ptkrs_pkg, ptkrs_ctrl and ptkrs_dpath
`timescale 1ns / 1ps
`default_nettype none

// streaming top-k row select: rows come in one word at a time; a row whose
// infeasibility is strictly above zero_threshold is a candidate, ranked by
// infeasibility / weight, compared exactly by 64-bit cross products. in global
// mode (mode 0) the best k rows are kept sorted, ties to the smaller row index;
// in partition mode (mode 1) the best row of each partition below k is kept,
// the earlier row winning a tie. on the row flagged last the kept rows go out
// in slot order, or one not-found word, and the store is emptied. one input
// word is taken at a time. a candidate is compared against the kept slots in
// turn (at most k in global mode, one in partition mode), each compare being a
// probe, two passes through the single 32x32 multiplier and a decide; a row
// that reaches an empty slot at a probe is put there. the last row passes a
// count state, then the emit state walks the slots up to the last kept one,
// sending each kept row (or one not-found word) and waiting out any output
// stall. the output register lets the list be taken while the next scan
// starts. writing mode or select_count empties the store.
module pricing_top_k_row_select_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [ptkrs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ptkrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // row words in
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [ptkrs_pkg::ROW_W-1:0]       row_i,
  input  wire logic [ptkrs_pkg::VAL_W-1:0]       infeasibility_i,
  input  wire logic [ptkrs_pkg::VAL_W-1:0]       weight_i,
  input  wire logic [ptkrs_pkg::PART_W-1:0]      partition_i,
  input  wire logic                              last_i,
  // result words out
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ptkrs_pkg::ROW_W-1:0]            chosen_row_o,
  output logic                                   found_o,
  output logic [ptkrs_pkg::RANK_W-1:0]           rank_o,
  output logic [ptkrs_pkg::SIZE_W-1:0]           list_size_o,
  output logic                                   end_of_list_o
);
  import ptkrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one row at a time, walks the kept slots
  ptkrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // slots, multiplier and the output register
  ptkrs_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .row_i           (row_i),
    .infeasibility_i (infeasibility_i),
    .weight_i        (weight_i),
    .partition_i     (partition_i),
    .last_i          (last_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .chosen_row_o    (chosen_row_o),
    .found_o         (found_o),
    .rank_o          (rank_o),
    .list_size_o     (list_size_o),
    .end_of_list_o   (end_of_list_o)
  );

endmodule

`default_nettype wire

### test/tb_pricing_top_k_row_select_core.sv
// self-checking testbench for the streaming top-k row select core
// depends on ptkrs_pkg and pricing_top_k_row_select_core
`timescale 1ns / 1ps

module tb_pricing_top_k_row_select_core;
  import ptkrs_pkg::*;

  // -------------------------------------------------------------------------
  // word types seen on the two streams
  // -------------------------------------------------------------------------
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [VAL_W-1:0]  inf;
    logic [VAL_W-1:0]  wt;
    logic [PART_W-1:0] part;
    logic              last;
  } row_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic              found;
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
    logic              eol;
  } pick_t;

  // a queued row word, optionally with a hand-written expected pick
  typedef struct packed {
    row_word_t w;
    logic      typed;
    pick_t     pick;
  } stim_word_t;

  typedef enum logic {
    DIR_ROW,
    DIR_CFG
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e        kind;
    row_word_t        w;
    logic             typed;
    pick_t            pick;
    logic [1:0]       idx;
    logic [31:0]      data;
  } dir_step_t;

  localparam int unsigned CYCLE_LIMIT   = 300_000;
  // settle time covers the longest candidate and a full emission
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned RANDOM_ROWS   = 400;
  // index past the register list, written to show it has no effect
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  localparam row_word_t NO_ROW    = '0;
  localparam pick_t     NO_PICK   = '0;
  localparam pick_t     NONE_PICK = '{16'h0000, 1'b0, 4'd0, 5'd0, 1'b1};

  // -------------------------------------------------------------------------
  // directed table: typed picks only where the answer is obvious, the rest
  // goes through the shortlist model
  // -------------------------------------------------------------------------
  localparam int DIR_STEPS = 35;
  localparam dir_step_t DIRECTED [DIR_STEPS] = '{
    // after reset: global, k 8, threshold 0; zero infeasibility is no candidate
    '{DIR_ROW, '{16'h1234, 32'h0, 32'h1, 4'h0, 1'b1}, 1'b1, NONE_PICK, 2'd0, 32'd0},
    // all-ones extremes, a lone candidate
    '{DIR_ROW, '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1}, 1'b1,
      '{16'hFFFF, 1'b1, 4'd0, 5'd1, 1'b1}, 2'd0, 32'd0},
    // equal merits, equal row index, zero weights tying with each other
    '{DIR_ROW, '{16'd5, 32'd10, 32'd2, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'd3, 32'd5, 32'd1, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'd5, 32'd20, 32'd4, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'd9, 32'd1, 32'd0, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'd8, 32'd7, 32'd0, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'd0, 32'd1, 32'hFFFF_FFFF, 4'h0, 1'b1}, 1'b0, NO_PICK, 2'd0, 32'd0},
    // k 2 with three candidates: one drops out
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_SELECT_COUNT, 32'd2},
    '{DIR_ROW, '{16'h0100, 32'h3_0000, 32'h1_0000, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0101, 32'h5_0000, 32'h1_0000, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0102, 32'h4_0000, 32'h1_0000, 4'h0, 1'b1}, 1'b0, NO_PICK, 2'd0, 32'd0},
    // count 0 acts as k 1
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_SELECT_COUNT, 32'd0},
    '{DIR_ROW, '{16'h0010, 32'd100, 32'd1, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0020, 32'd200, 32'd1, 4'h0, 1'b1}, 1'b1,
      '{16'h0020, 1'b1, 4'd0, 5'd1, 1'b1}, 2'd0, 32'd0},
    // count above 16 acts as 16; partition mode, threshold at one
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_SELECT_COUNT, 32'd31},
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_MODE, 32'd1},
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_ZERO_THRESHOLD, 32'h1_0000},
    '{DIR_ROW, '{16'h0200, 32'h2_0000, 32'd1, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0201, 32'h2_0000, 32'd1, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0202, 32'h1_0000, 32'd1, 4'hF, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0203, 32'h3_0000, 32'h1_0000, 4'h3, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0204, 32'hFFFF_FFFF, 32'd1, 4'hF, 1'b1}, 1'b0, NO_PICK, 2'd0, 32'd0},
    // partition beyond k is dropped
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_SELECT_COUNT, 32'd4},
    '{DIR_ROW, '{16'h0300, 32'hFFFF_FFFF, 32'd1, 4'h7, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_ROW, '{16'h0301, 32'h2_0000, 32'd2, 4'h1, 1'b1}, 1'b1,
      '{16'h0301, 1'b1, 4'd0, 5'd1, 1'b1}, 2'd0, 32'd0},
    // mode rewrite mid-scan throws the kept row away
    '{DIR_ROW, '{16'h0400, 32'h2_0000, 32'd1, 4'h2, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_MODE, 32'd0},
    '{DIR_ROW, '{16'h0401, 32'h1_8000, 32'd1, 4'h0, 1'b1}, 1'b1,
      '{16'h0401, 1'b1, 4'd0, 5'd1, 1'b1}, 2'd0, 32'd0},
    // threshold rewrite and an unused index leave the scan alone
    '{DIR_ROW, '{16'h0500, 32'h5_0000, 32'd1, 4'h0, 1'b0}, 1'b0, NO_PICK, 2'd0, 32'd0},
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_UNUSED, 32'hFFFF_FFFF},
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_ZERO_THRESHOLD, 32'd0},
    '{DIR_ROW, '{16'h0501, 32'd1, 32'hFFFF_FFFF, 4'h0, 1'b1}, 1'b0, NO_PICK, 2'd0, 32'd0},
    // top threshold: nothing can be a candidate
    '{DIR_CFG, NO_ROW, 1'b0, NO_PICK, REG_ZERO_THRESHOLD, 32'hFFFF_FFFF},
    '{DIR_ROW, '{16'h0600, 32'hFFFF_FFFF, 32'd1, 4'hF, 1'b1}, 1'b1, NONE_PICK, 2'd0, 32'd0}
  };

  // -------------------------------------------------------------------------
  // clock, reset and dut
  // -------------------------------------------------------------------------
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [ROW_W-1:0]      row_i           = '0;
  logic [VAL_W-1:0]      infeasibility_i = '0;
  logic [VAL_W-1:0]      weight_i        = '0;
  logic [PART_W-1:0]     partition_i     = '0;
  logic                  last_i          = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [ROW_W-1:0]      chosen_row_o;
  logic                  found_o;
  logic [RANK_W-1:0]     rank_o;
  logic [SIZE_W-1:0]     list_size_o;
  logic                  end_of_list_o;

  always #5 clk_i = ~clk_i;

  pricing_top_k_row_select_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .row_i           (row_i),
    .infeasibility_i (infeasibility_i),
    .weight_i        (weight_i),
    .partition_i     (partition_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .chosen_row_o    (chosen_row_o),
    .found_o         (found_o),
    .rank_o          (rank_o),
    .list_size_o     (list_size_o),
    .end_of_list_o   (end_of_list_o)
  );

  // -------------------------------------------------------------------------
  // shortlist model: own copy of the registers and of the kept slots
  // -------------------------------------------------------------------------
  logic             sel_mode      = 1'b0;
  logic [4:0]       sel_count     = 5'd8;
  logic [VAL_W-1:0] sel_threshold = '0;

  logic [ROW_W-1:0] short_row  [MAX_K] = '{default: '0};
  logic [VAL_W-1:0] short_inf  [MAX_K] = '{default: '0};
  logic [VAL_W-1:0] short_wt   [MAX_K] = '{default: 32'd1};
  logic             short_used [MAX_K] = '{default: 1'b0};

  pick_t      fresh_picks [$];   // picks caused by the row just taken
  pick_t      picks_due   [$];   // picks still to come out of the dut
  stim_word_t words_to_send [$];
  stim_word_t word_on_bus;

  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  logic        calm         = 1'b0;  // no idling on either side while set
  pick_t       head_pick;

  // k clamped into 1..MAX_K
  function automatic int clamp_k(logic [4:0] sc);
    if (sc == 5'd0) return 1;
    if (int'(sc) > MAX_K) return MAX_K;
    return int'(sc);
  endfunction

  // sign of (inf_a / wt_a) - (inf_b / wt_b), by exact cross products
  function automatic int merit_order(logic [31:0] inf_a, logic [31:0] wt_a,
                                     logic [31:0] inf_b, logic [31:0] wt_b);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(inf_a) * 64'(wt_b);
    rhs = 64'(inf_b) * 64'(wt_a);
    if (lhs > rhs) return 1;
    if (lhs == rhs) return 0;
    return -1;
  endfunction

  function automatic void clear_shortlist();
    for (int s = 0; s < MAX_K; s++) short_used[s] = 1'b0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_MODE: begin
        sel_mode = data[0];
        clear_shortlist();
      end
      REG_SELECT_COUNT: begin
        sel_count = data[4:0];
        clear_shortlist();
      end
      REG_ZERO_THRESHOLD: begin
        sel_threshold = data;
      end
      default: begin
      end
    endcase
  endfunction

  // folds one row into the shortlist; on the last row fills fresh_picks
  function automatic void update_shortlist(row_word_t w);
    int    k;
    int    p;
    int    c;
    int    n;
    int    e;
    pick_t pk;
    k = clamp_k(sel_count);
    fresh_picks.delete();
    if (w.inf > sel_threshold) begin
      if (sel_mode) begin
        // one slot per partition, the earlier row keeps a tie
        if (int'(w.part) < k) begin
          if (!short_used[w.part] ||
              merit_order(w.inf, w.wt, short_inf[w.part], short_wt[w.part]) > 0) begin
            short_row[w.part]  = w.row;
            short_inf[w.part]  = w.inf;
            short_wt[w.part]   = w.wt;
            short_used[w.part] = 1'b1;
          end
        end
      end else begin
        // sorted prefix: merit descending, then smaller row index first
        p = 0;
        while (p < k && short_used[p]) begin
          c = merit_order(w.inf, w.wt, short_inf[p], short_wt[p]);
          if (c > 0 || (c == 0 && w.row < short_row[p])) break;
          p++;
        end
        if (p < k) begin
          for (int j = k - 1; j > p; j--) begin
            short_row[j]  = short_row[j-1];
            short_inf[j]  = short_inf[j-1];
            short_wt[j]   = short_wt[j-1];
            short_used[j] = short_used[j-1];
          end
          short_row[p]  = w.row;
          short_inf[p]  = w.inf;
          short_wt[p]   = w.wt;
          short_used[p] = 1'b1;
        end
      end
    end
    if (!w.last) return;
    n = 0;
    for (int s = 0; s < k; s++) if (short_used[s]) n++;
    if (n == 0) begin
      fresh_picks = {fresh_picks, NONE_PICK};
    end else begin
      e = 0;
      for (int s = 0; s < k; s++) begin
        if (short_used[s]) begin
          pk.row   = short_row[s];
          pk.found = 1'b1;
          pk.rank  = RANK_W'(e);
          pk.size  = SIZE_W'(n);
          pk.eol   = (e + 1 == n);
          fresh_picks = {fresh_picks, pk};
          e++;
        end
      end
    end
    clear_shortlist();
  endfunction

  // -------------------------------------------------------------------------
  // row word sender: valid holds until taken, random gaps between words
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        update_shortlist(word_on_bus.w);
        // hand-written picks replace the model's for that row
        if (word_on_bus.typed) begin
          picks_due = {picks_due, word_on_bus.pick};
        end else begin
          picks_due = {picks_due, fresh_picks};
        end
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
          word_on_bus      = words_to_send.pop_front();
          in_valid_i      <= 1'b1;
          row_i           <= word_on_bus.w.row;
          infeasibility_i <= word_on_bus.w.inf;
          weight_i        <= word_on_bus.w.wt;
          partition_i     <= word_on_bus.w.part;
          last_i          <= word_on_bus.w.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // pick receiver and checker, with random back-pressure
  // -------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (picks_due.size() == 0) begin
          flag_mismatch("unexpected word, chosen_row", 32'(chosen_row_o), 32'd0);
        end else begin
          head_pick = picks_due.pop_front();
          if (chosen_row_o !== head_pick.row)
            flag_mismatch("chosen_row", 32'(chosen_row_o), 32'(head_pick.row));
          if (found_o !== head_pick.found)
            flag_mismatch("found", 32'(found_o), 32'(head_pick.found));
          if (rank_o !== head_pick.rank)
            flag_mismatch("rank", 32'(rank_o), 32'(head_pick.rank));
          if (list_size_o !== head_pick.size)
            flag_mismatch("list_size", 32'(list_size_o), 32'(head_pick.size));
          if (end_of_list_o !== head_pick.eol)
            flag_mismatch("end_of_list", 32'(end_of_list_o), 32'(head_pick.eol));
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 8);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL pricing_top_k_row_select_core");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers, all entered just after a rising edge
  // -------------------------------------------------------------------------
  task automatic queue_word(row_word_t w, logic typed, pick_t pick);
    stim_word_t sw;
    sw = '{w, typed, pick};
    words_to_send = {words_to_send, sw};
    words_queued++;
  endtask

  // every word taken, every pick out, then time for the core to go quiet
  task automatic wait_idle();
    while (words_taken != words_queued || picks_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned scan_no;
    int unsigned len;
    logic        torn;
    row_word_t   w;
    logic [31:0] thr;
    sent    = 0;
    scan_no = 0;
    torn    = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; register writes wait for the core to go idle
    for (int i = 0; i < DIR_STEPS; i++) begin
      if (DIRECTED[i].kind == DIR_CFG) begin
        wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        queue_word(DIRECTED[i].w, DIRECTED[i].typed, DIRECTED[i].pick);
      end
    end

    // random scans: mostly complete scans, now and then one cut short by a
    // register write; settings change every few scans
    while (sent < RANDOM_ROWS) begin
      if (torn || scan_no % 4 == 0) begin
        wait_idle();
        write_reg(REG_MODE, 32'($urandom_range(0, 1)));
        if ($urandom_range(5) == 0) write_reg(REG_SELECT_COUNT, $urandom_range(0, 31));
        else write_reg(REG_SELECT_COUNT, $urandom_range(1, 16));
        case ($urandom_range(5))
          0, 1:    thr = 32'd0;
          2:       thr = $urandom_range(0, 32);
          3:       thr = $urandom_range(0, 4) << 16;
          4:       thr = $urandom();
          default: thr = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        write_reg(REG_ZERO_THRESHOLD, thr);
      end else if ($urandom_range(9) == 0) begin
        // hold off until the core has drained
        wait_idle();
      end
      calm <= (scan_no >= 8 && scan_no < 14);
      torn = ($urandom_range(11) == 0);
      len  = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        // small rows and ratios make ties on merit and on index likely
        w.row = ROW_W'(($urandom_range(3) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(0, 65535));
        case ($urandom_range(3))
          0:       w.inf = $urandom();
          1:       w.inf = $urandom_range(0, 64);
          2:       w.inf = $urandom_range(0, 4) << 16;
          default: w.inf = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(3))
          0:       w.wt = $urandom_range(1, 8);
          1:       w.wt = 32'h1_0000 << $urandom_range(0, 15);
          2:       w.wt = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : 32'h1;
          default: w.wt = $urandom_range(1, 32'hFFFF_FFFF);
        endcase
        w.part = PART_W'($urandom_range(0, 15));
        w.last = (i == len - 1) && !torn;
        queue_word(w, 1'b0, NO_PICK);
        sent++;
      end
      scan_no++;
    end

    wait_idle();
    if (error_count == 0) $display("PASS pricing_top_k_row_select_core");
    else $display("FAIL pricing_top_k_row_select_core");
    $finish;
  end

endmodule
